FILE: hw/rtl/ple_pkg.sv
`default_nettype none
package ple_pkg;
    localparam int Capacity  = 16;
    localparam int DataWidth = 32;
    localparam int IdxW      = $clog2(Capacity);
    localparam int CntW      = $clog2(Capacity + 1);

    typedef enum logic [3:0] {
        REQ_INS_FRONT = 4'd0, REQ_INS_BACK = 4'd1, REQ_INS_AT = 4'd2,
        REQ_DEL_FRONT = 4'd3, REQ_DEL_BACK = 4'd4, REQ_DEL_AT = 4'd5,
        REQ_DEL_VALUE = 4'd6, REQ_RD_FRONT = 4'd7, REQ_RD_BACK = 4'd8,
        REQ_RD_AT = 4'd9, REQ_FIND = 4'd10, REQ_EXISTS = 4'd11,
        REQ_CLEAR = 4'd12, REQ_NOP13 = 4'd13, REQ_NOP14 = 4'd14, REQ_NOP15 = 4'd15
    } req_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_FULL = 2'd1, ST_BADPOS = 2'd2, ST_NOTFOUND = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic rd_en;      // read store at rd_addr
        logic [IdxW-1:0] rd_addr;
        logic wr_en;
        logic [IdxW-1:0] wr_addr;
        logic wr_sel_val; // write request value instead of read data
        logic cmp_en;     // compare read data with request value
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic cap_read;   // latch read data as result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CntW-1:0] count;
        logic match;      // registered read data equals value
    } sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ple_datapath.sv
`default_nettype none
module ple_datapath
    import ple_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic [DataWidth-1:0] req_value,
    output sts_t                      sts,
    output logic [DataWidth-1:0]      rd_value
);
    logic [DataWidth-1:0] mem [Capacity];
    logic [DataWidth-1:0] val_reg;
    logic [DataWidth-1:0] rdata_reg;
    logic [DataWidth-1:0] res_reg;
    logic [CntW-1:0]      count_reg;
    logic [CntW-1:0]      count_next;

    always_ff @(posedge aclk) begin
        if (cmd.load) val_reg <= req_value;
        if (cmd.rd_en) rdata_reg <= mem[cmd.rd_addr];
        if (cmd.wr_en) mem[cmd.wr_addr] <= cmd.wr_sel_val ? val_reg : rdata_reg;
        if (cmd.cap_read) res_reg <= rdata_reg;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_clr) count_next = '0;
        else if (cmd.cnt_inc) count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else count_reg <= count_next;
    end

    assign sts.count = count_reg;
    assign sts.match = cmd.cmp_en && (rdata_reg == val_reg);
    assign rd_value  = res_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(Capacity)) else $error("count above capacity");
    a_inc_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> count_reg < CntW'(Capacity)) else $error("inc when full");
    a_dec_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |-> count_reg != '0) else $error("dec when empty");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/ple_ctrl.sv
`default_nettype none
module ple_ctrl
    import ple_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [3:0]      in_req,
    input  wire logic [4:0]      in_pos,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire sts_t            sts,
    output cmd_t                 cmd,
    output logic                 rd_sel,
    output logic                 res_found,
    output logic [IdxW-1:0]      res_index,
    output logic [1:0]           res_status
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010, // decide from count and position
        S_SHUP  = 7'b0000100, // shift up: read i-1, write i
        S_SHDN  = 7'b0001000, // shift down: read i+1, write i
        S_SCAN  = 7'b0010000, // search: read i, compare next cycle
        S_RD    = 7'b0100000, // wait for the registered read data
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    req_t req_reg, req_next;
    logic [CntW-1:0] pos_reg, pos_next;    // target position
    logic [CntW-1:0] i_reg, i_next;        // walking index
    logic ph_reg, ph_next;                 // read/write phase
    logic found_reg, found_next, rd_reg, rd_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [1:0] st_reg, st_next;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] ipos;

    assign cnt = sts.count;
    assign ipos = CntW'(in_pos);

    always_comb begin
        state_next = state_reg; req_next = req_reg; pos_next = pos_reg;
        i_next = i_reg; ph_next = ph_reg; found_next = found_reg;
        idx_next = idx_reg; st_next = st_reg; rd_next = rd_reg;
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    req_next = req_t'(in_req);
                    pos_next = (CntW >= 5) ? ipos : CntW'(in_pos);
                    found_next = 1'b0; idx_next = '0; st_next = ST_OK; rd_next = 1'b0;
                    ph_next = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_OUT;
                case (req_reg)
                    REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
                        if (cnt >= CntW'(Capacity)) st_next = ST_FULL;
                        else if (req_reg == REQ_INS_AT && pos_reg > cnt) st_next = ST_BADPOS;
                        else begin
                            if (req_reg == REQ_INS_FRONT) pos_next = '0;
                            if (req_reg == REQ_INS_BACK) pos_next = cnt;
                            i_next = cnt; state_next = S_SHUP;
                        end
                    end
                    REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
                        if (cnt == '0) st_next = ST_BADPOS;
                        else if (req_reg == REQ_DEL_AT && pos_reg >= cnt) st_next = ST_BADPOS;
                        else begin
                            if (req_reg == REQ_DEL_FRONT) i_next = '0;
                            else if (req_reg == REQ_DEL_BACK) i_next = cnt - 1'b1;
                            else i_next = pos_reg;
                            state_next = S_SHDN;
                        end
                    end
                    REQ_DEL_VALUE, REQ_FIND, REQ_EXISTS: begin
                        if (cnt == '0) begin
                            if (req_reg == REQ_DEL_VALUE) st_next = ST_BADPOS;
                            else if (req_reg == REQ_FIND) st_next = ST_NOTFOUND;
                        end else begin
                            i_next = '0; state_next = S_SCAN;
                        end
                    end
                    REQ_RD_FRONT, REQ_RD_BACK, REQ_RD_AT: begin
                        if (cnt == '0) st_next = ST_BADPOS;
                        else if (req_reg == REQ_RD_AT && pos_reg >= cnt) st_next = ST_BADPOS;
                        else begin
                            cmd.rd_en = 1'b1;
                            if (req_reg == REQ_RD_FRONT) cmd.rd_addr = '0;
                            else if (req_reg == REQ_RD_BACK) cmd.rd_addr = IdxW'(cnt - 1'b1);
                            else cmd.rd_addr = IdxW'(pos_reg);
                            state_next = S_RD;
                        end
                    end
                    REQ_CLEAR: cmd.cnt_clr = 1'b1;
                    default: ;
                endcase
            end
            S_SHUP: begin
                if (i_reg == pos_reg) begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(i_reg); cmd.wr_sel_val = 1'b1;
                    cmd.cnt_inc = 1'b1; state_next = S_OUT;
                end else if (!ph_reg) begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_reg - 1'b1); ph_next = 1'b1;
                end else begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(i_reg);
                    i_next = i_reg - 1'b1; ph_next = 1'b0;
                end
            end
            S_SHDN: begin
                if (i_reg + 1'b1 >= cnt) begin
                    cmd.cnt_dec = 1'b1; state_next = S_OUT;
                end else if (!ph_reg) begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_reg + 1'b1); ph_next = 1'b1;
                end else begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = IdxW'(i_reg);
                    i_next = i_reg + 1'b1; ph_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (!ph_reg) begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = IdxW'(i_reg); ph_next = 1'b1;
                end else begin
                    cmd.cmp_en = 1'b1; ph_next = 1'b0;
                    if (sts.match) begin
                        if (req_reg == REQ_DEL_VALUE) state_next = S_SHDN;
                        else begin
                            found_next = 1'b1; idx_next = IdxW'(i_reg); state_next = S_OUT;
                        end
                    end else if (i_reg + 1'b1 >= cnt) begin
                        if (req_reg != REQ_EXISTS) st_next = ST_NOTFOUND;
                        state_next = S_OUT;
                    end else i_next = i_reg + 1'b1;
                end
            end
            S_RD: begin
                cmd.cap_read = 1'b1; rd_next = 1'b1; state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; ph_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ph_reg <= ph_next;
        end
        req_reg <= req_next; pos_reg <= pos_next; i_reg <= i_next;
        found_reg <= found_next; idx_reg <= idx_next; st_reg <= st_next; rd_reg <= rd_next;
    end

    assign rd_sel = rd_reg;
    assign res_found = found_reg;
    assign res_index = idx_reg;
    assign res_status = st_reg;

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_no_acc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE) else $error("load while busy");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/positional_list_engine_unit.sv
`default_nettype none
// ordered list of up to 16 32-bit words in a fixed store, one word per request
// and one result word per request. each entry moved or scanned takes a read and
// then a write or a compare, set by the single read port of the store; one
// request is in flight at a time and the next is taken once the result word
// leaves. no clearing pass: only entries below the count are ever read.
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [3:0]           s_req_type,
    input  wire logic [4:0]           s_position,
    input  wire logic [31:0]          s_item_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [31:0]               m_read_value,
    output logic                      m_found,
    output logic [3:0]                m_found_index,
    output logic [4:0]                m_element_count,
    output logic                      m_is_empty,
    output logic                      m_is_full,
    output logic [1:0]                m_status
);
    cmd_t cmd;
    sts_t sts;
    logic rd_sel;
    logic [DataWidth-1:0] rd_value;
    logic [IdxW-1:0] res_index;

    // sequencer: decides, walks the shift or scan, holds the result word
    ple_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .in_req(s_req_type), .in_pos(s_position),
        .out_valid(m_valid), .out_ready(m_ready),
        .sts, .cmd, .rd_sel,
        .res_found(m_found), .res_index, .res_status(m_status)
    );

    // store, count and comparator
    ple_datapath u_dp (
        .aclk, .aresetn, .cmd,
        .req_value(DataWidth'(s_item_value)),
        .sts, .rd_value
    );

    assign m_read_value    = rd_sel ? 32'(rd_value) : 32'd0;
    assign m_found_index   = 4'(res_index);
    assign m_element_count = 5'(sts.count);
    assign m_is_empty      = (sts.count == '0);
    assign m_is_full       = (sts.count >= CntW'(Capacity));
endmodule
`default_nettype wire
